FILE: design/assert_macros.svh
// Assertion macros shared by the summed-area table RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: implication check failed");
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: design/rsat_pkg.sv
// Shared types, constants and codes for the RGB summed-area table core.
// No dependencies.
package rsat_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W     = $clog2(CELLS);

	localparam int DIM_W  = 9;
	localparam int PIX_W  = 17;
	localparam int SUM_W  = 24;
	localparam int SQ_W   = 32;
	localparam int VAR_W  = 42;
	localparam int AREA_W = 17;
	localparam int AVG_W  = 8;
	localparam int PROD_W = SQ_W + AREA_W;
	localparam int NUM_W  = PROD_W + 2;
	localparam int DVD_W  = NUM_W + 8;
	localparam int CNT_W  = $clog2(DVD_W + 1);

	localparam int RESET_W = (256 > MAX_WIDTH) ? MAX_WIDTH : 256;
	localparam int RESET_H = (256 > MAX_HEIGHT) ? MAX_HEIGHT : 256;

	localparam logic CFG_IMAGE_WIDTH  = 1'b0;
	localparam logic CFG_IMAGE_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_QUERY   = 2'd1,
		OP_RESTART = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_OUTSIDE    = 2'd1,
		ST_NOT_LOADED = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_LD_RD, S_LD_WR, S_Q_CHK, S_Q_RD, S_Q_ACC,
		S_Q_MUL, S_Q_NUM, S_Q_DIV, S_Q_DWAIT, S_Q_OUT
	} state_t;

	typedef struct packed {
		logic [1:0]       op;
		logic [7:0]       red;
		logic [7:0]       green;
		logic [7:0]       blue;
		logic [7:0]       x_left;
		logic [7:0]       y_top;
		logic [DIM_W-1:0] rect_width;
		logic [DIM_W-1:0] rect_height;
	} in_item_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum_red;
		logic [SUM_W-1:0] sum_green;
		logic [SUM_W-1:0] sum_blue;
		logic [SQ_W-1:0]  sumsq_red;
		logic [SQ_W-1:0]  sumsq_green;
		logic [SQ_W-1:0]  sumsq_blue;
		logic [VAR_W-1:0] variance;
		logic [AVG_W-1:0] avg_red;
		logic [AVG_W-1:0] avg_green;
		logic [AVG_W-1:0] avg_blue;
		logic [1:0]       status;
	} out_item_t;

	// one table word: all six tables at one cell
	typedef struct packed {
		logic [2:0][SUM_W-1:0] sum;
		logic [2:0][SQ_W-1:0]  sq;
	} cell_t;

	typedef struct packed {
		logic       latch;
		logic       restart;
		logic       ld_write;
		logic       q_check;
		logic       rd_corner;
		logic       acc;
		logic       mul;
		logic       num;
		logic       div_start;
		logic       div_store;
		logic       out_load;
		logic [1:0] sel;
	} cmd_t;

	typedef struct packed {
		logic complete;
		logic q_run;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

FILE: design/rsat_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rsat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: design/rsat_div.sv
// Restoring divider, one quotient bit per cycle, dividend left-aligned.
// Depends on rsat_pkg.
module rsat_div import rsat_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DVD_W-1:0]  dividend,
	input  logic [CNT_W-1:0]  len,
	input  logic [AREA_W-1:0] divisor,
	output logic              done,
	output logic [DVD_W-1:0]  quotient
);

	logic [CNT_W-1:0]  cnt_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [DVD_W-1:0]  quo_q;
	logic [AREA_W-1:0] rem_q;
	logic [AREA_W:0]   trial;
	logic              ge;

	// trial subtract of the next dividend bit
	always_comb begin
		trial = {rem_q, dvd_q[DVD_W-1]};
		ge    = trial >= {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= len;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			quo_q <= '0;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			quo_q <= {quo_q[DVD_W-2:0], ge};
			rem_q <= ge ? AREA_W'(trial - {1'b0, divisor}) : trial[AREA_W-1:0];
		end
	end

	assign done     = cnt_q == '0;
	assign quotient = quo_q;

endmodule

FILE: design/rsat_dp.sv
// Datapath: load counters, table RAM, corner accumulation, products,
// divider and result registers. Depends on rsat_pkg, rsat_ram, rsat_div.
module rsat_dp import rsat_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	output sts_t       sts,
	input  in_item_t   in_data,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [8:0] cfg_data,
	output logic       out_valid,
	input  logic       out_stall,
	output out_item_t  out_data
);

	function automatic logic [ADDR_W-1:0] cell_addr(logic [9:0] col, logic [9:0] row);
		return ADDR_W'(row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col);
	endfunction

	function automatic logic [DIM_W-1:0] clamp_dim(logic [8:0] v, int max_dim);
		logic [DIM_W-1:0] r;
		if (v == '0) r = DIM_W'(1);
		else if (32'(v) > max_dim) r = DIM_W'(max_dim);
		else r = v;
		return r;
	endfunction

	logic [DIM_W-1:0] img_w_q, img_h_q;
	logic [PIX_W-1:0] pix_q;
	logic [DIM_W-1:0] col_q, row_q;
	logic [2:0][SUM_W-1:0] rowsum_q;
	logic [2:0][SQ_W-1:0]  rowsq_q;
	in_item_t item_q;

	logic [17:0] total;
	logic        complete;
	logic [9:0]  x1, y1;
	logic        empty, outside;
	logic [1:0]  q_status;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr, above_addr, corner_addr;
	cell_t             ram_wdata, ram_rdata;
	logic [2:0][7:0]   pix_val;
	logic [2:0][SUM_W-1:0] rowsum_n;
	logic [2:0][SQ_W-1:0]  rowsq_n;

	logic [9:0] c_col, c_row;
	logic       c_neg;
	logic       zero_s1, neg_s1;

	logic [AREA_W-1:0]     area_q;
	logic [9:0]            x1_q, y1_q;
	logic [2:0][SUM_W-1:0] acc_sum_q;
	logic [2:0][SQ_W-1:0]  acc_sq_q;
	logic [2:0][PROD_W-1:0] a_q;
	logic [2:0][PROD_W-1:0] b_q;
	logic [NUM_W-1:0]      num_q;
	logic [NUM_W-1:0]      num_n;

	logic [DVD_W-1:0] div_dvd, div_quo;
	logic [CNT_W-1:0] div_len;
	logic             div_done;
	out_item_t        res_q, out_q;
	logic             out_valid_q;

	// image state and query checks
	always_comb begin
		total    = 18'(img_w_q) * 18'(img_h_q);
		complete = 18'(pix_q) >= total;
		x1       = 10'(item_q.x_left) + 10'(item_q.rect_width);
		y1       = 10'(item_q.y_top) + 10'(item_q.rect_height);
		empty    = item_q.rect_width == '0 || item_q.rect_height == '0;
		outside  = x1 > 10'(img_w_q) || y1 > 10'(img_h_q);
		if (!complete) q_status = ST_NOT_LOADED;
		else if (!empty && outside) q_status = ST_OUTSIDE;
		else q_status = ST_OK;
	end

	assign sts.complete = complete;
	assign sts.q_run    = complete && !empty && !outside;
	assign sts.div_done = div_done;
	assign sts.out_free = !out_valid_q || !out_stall;

	// configuration and load counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q <= DIM_W'(RESET_W);
			img_h_q <= DIM_W'(RESET_H);
			pix_q   <= '0;
			col_q   <= '0;
			row_q   <= '0;
		end else if (cfg_we || cmd.restart) begin
			if (cfg_we && cfg_index == CFG_IMAGE_WIDTH) img_w_q <= clamp_dim(cfg_data, MAX_WIDTH);
			if (cfg_we && cfg_index == CFG_IMAGE_HEIGHT) img_h_q <= clamp_dim(cfg_data, MAX_HEIGHT);
			pix_q <= '0;
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.ld_write) begin
			pix_q <= pix_q + 1'b1;
			if (col_q == img_w_q - 1'b1) begin
				col_q <= '0;
				row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) item_q <= in_data;
	end

	// new table word: running row sum plus the word above
	always_comb begin
		pix_val = {item_q.blue, item_q.green, item_q.red};
		for (int c = 0; c < 3; c++) begin
			rowsum_n[c] = (col_q == '0 ? '0 : rowsum_q[c]) + SUM_W'(pix_val[c]);
			rowsq_n[c]  = (col_q == '0 ? '0 : rowsq_q[c])
				+ SQ_W'(16'(pix_val[c]) * 16'(pix_val[c]));
			ram_wdata.sum[c] = rowsum_n[c] + (row_q == '0 ? '0 : ram_rdata.sum[c]);
			ram_wdata.sq[c]  = rowsq_n[c] + (row_q == '0 ? '0 : ram_rdata.sq[c]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_write) begin
			rowsum_q <= rowsum_n;
			rowsq_q  <= rowsq_n;
		end
	end

	// corner select: A and D add, B and C subtract
	always_comb begin
		unique case (cmd.sel)
			2'd0: begin c_col = x1_q; c_row = y1_q; c_neg = 1'b0; end
			2'd1: begin c_col = 10'(item_q.x_left); c_row = y1_q; c_neg = 1'b1; end
			2'd2: begin c_col = x1_q; c_row = 10'(item_q.y_top); c_neg = 1'b1; end
			default: begin
				c_col = 10'(item_q.x_left); c_row = 10'(item_q.y_top); c_neg = 1'b0;
			end
		endcase
		corner_addr = cell_addr(c_col - 10'd1, c_row - 10'd1);
		above_addr  = cell_addr(10'(col_q), 10'(row_q) - 10'd1);
		ram_we      = cmd.ld_write;
		ram_waddr   = cell_addr(10'(col_q), 10'(row_q));
		ram_raddr   = cmd.rd_corner ? corner_addr : above_addr;
	end

	rsat_ram #(.WIDTH($bits(cell_t)), .DEPTH(CELLS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// clipped variance numerator
	always_comb begin
		num_n = '0;
		for (int c = 0; c < 3; c++) begin
			if (a_q[c] > b_q[c]) num_n = num_n + NUM_W'(a_q[c] - b_q[c]);
		end
	end

	// query arithmetic
	always_ff @(posedge clk) begin
		if (cmd.rd_corner) begin
			zero_s1 <= c_col == '0 || c_row == '0;
			neg_s1  <= c_neg;
		end
		if (cmd.q_check) begin
			area_q    <= AREA_W'(18'(item_q.rect_width) * 18'(item_q.rect_height));
			x1_q      <= x1;
			y1_q      <= y1;
			acc_sum_q <= '0;
			acc_sq_q  <= '0;
		end
		if (cmd.acc) begin
			for (int c = 0; c < 3; c++) begin
				if (zero_s1) begin
					acc_sum_q[c] <= acc_sum_q[c];
					acc_sq_q[c]  <= acc_sq_q[c];
				end else if (neg_s1) begin
					acc_sum_q[c] <= acc_sum_q[c] - ram_rdata.sum[c];
					acc_sq_q[c]  <= acc_sq_q[c] - ram_rdata.sq[c];
				end else begin
					acc_sum_q[c] <= acc_sum_q[c] + ram_rdata.sum[c];
					acc_sq_q[c]  <= acc_sq_q[c] + ram_rdata.sq[c];
				end
			end
		end
		if (cmd.mul) begin
			for (int c = 0; c < 3; c++) begin
				a_q[c] <= PROD_W'(acc_sq_q[c]) * PROD_W'(area_q);
				b_q[c] <= PROD_W'(acc_sum_q[c]) * PROD_W'(acc_sum_q[c]);
			end
		end
		if (cmd.num) begin
			num_q <= num_n;
		end
	end

	// divider operands: three means, then the variance
	always_comb begin
		if (cmd.sel == 2'd3) begin
			div_dvd = {num_q, 8'd0};
			div_len = CNT_W'(DVD_W);
		end else begin
			div_dvd = {acc_sum_q[cmd.sel], (DVD_W - SUM_W)'(0)};
			div_len = CNT_W'(SUM_W);
		end
	end

	rsat_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dvd),
		.len      (div_len),
		.divisor  (area_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// result assembly
	always_ff @(posedge clk) begin
		if (cmd.q_check) begin
			res_q <= '{status: q_status, default: '0};
		end
		if (cmd.num) begin
			res_q.sum_red     <= acc_sum_q[0];
			res_q.sum_green   <= acc_sum_q[1];
			res_q.sum_blue    <= acc_sum_q[2];
			res_q.sumsq_red   <= acc_sq_q[0];
			res_q.sumsq_green <= acc_sq_q[1];
			res_q.sumsq_blue  <= acc_sq_q[2];
		end
		if (cmd.div_store) begin
			unique case (cmd.sel)
				2'd0: res_q.avg_red <= div_quo > DVD_W'(255) ? 8'hFF : div_quo[7:0];
				2'd1: res_q.avg_green <= div_quo > DVD_W'(255) ? 8'hFF : div_quo[7:0];
				2'd2: res_q.avg_blue <= div_quo > DVD_W'(255) ? 8'hFF : div_quo[7:0];
				default: res_q.variance <= div_quo[DVD_W-1:VAR_W] != '0 ? '1 :
						div_quo[VAR_W-1:0];
			endcase
		end
		if (cmd.out_load) out_q <= res_q;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

FILE: design/rsat_ctrl.sv
// Controller state machine sequencing loads and queries.
// Depends on rsat_pkg.
module rsat_ctrl import rsat_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] op,
	input  sts_t       sts,
	output logic       in_stall,
	output cmd_t       cmd,
	output state_t     state
);

	state_t     state_q, state_n;
	logic [1:0] cnt_q, cnt_n;
	logic       take;

	assign take = in_valid && state_q == S_IDLE;

	// next state
	always_comb begin
		state_n = state_q;
		cnt_n   = cnt_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (op == OP_LOAD && !sts.complete) state_n = S_LD_RD;
					else if (op == OP_QUERY) state_n = S_Q_CHK;
				end
			end
			S_LD_RD: state_n = S_LD_WR;
			S_LD_WR: state_n = S_IDLE;
			S_Q_CHK: begin
				cnt_n   = '0;
				state_n = sts.q_run ? S_Q_RD : S_Q_OUT;
			end
			S_Q_RD: state_n = S_Q_ACC;
			S_Q_ACC: begin
				cnt_n   = cnt_q + 1'b1;
				state_n = cnt_q == 2'd3 ? S_Q_MUL : S_Q_RD;
			end
			S_Q_MUL: state_n = S_Q_NUM;
			S_Q_NUM: begin
				cnt_n   = '0;
				state_n = S_Q_DIV;
			end
			S_Q_DIV: state_n = S_Q_DWAIT;
			S_Q_DWAIT: begin
				if (sts.div_done) begin
					cnt_n   = cnt_q + 1'b1;
					state_n = cnt_q == 2'd3 ? S_Q_OUT : S_Q_DIV;
				end
			end
			S_Q_OUT: if (sts.out_free) state_n = S_IDLE;
			default: state_n = S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd           = '0;
		cmd.sel       = cnt_q;
		cmd.latch     = take;
		cmd.restart   = take && op == OP_RESTART;
		cmd.ld_write  = state_q == S_LD_WR;
		cmd.q_check   = state_q == S_Q_CHK;
		cmd.rd_corner = state_q == S_Q_RD;
		cmd.acc       = state_q == S_Q_ACC;
		cmd.mul       = state_q == S_Q_MUL;
		cmd.num       = state_q == S_Q_NUM;
		cmd.div_start = state_q == S_Q_DIV;
		cmd.div_store = state_q == S_Q_DWAIT && sts.div_done;
		cmd.out_load  = state_q == S_Q_OUT && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_n;
			cnt_q   <= cnt_n;
		end
	end

	assign in_stall = state_q != S_IDLE;
	assign state    = state_q;

endmodule

FILE: design/rgb_summed_area_table_core.sv
// RGB summed-area table core: each load pixel takes a table read, then a write.
// A query makes four corner reads on the one table read port, then four serial
// divisions (3 x 24, 1 x 59 bits); a new item is taken only once back in idle.
// Not-loaded, empty or outside queries skip the corner reads and divisions.
// Reset clears the pixel count and sets both dimensions to 256; table RAM is
// not cleared, entries are valid once loaded.
`include "assert_macros.svh"
module rgb_summed_area_table_core import rsat_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_item_t   in_data,
	output logic       out_valid,
	input  logic       out_stall,
	output out_item_t  out_data,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [8:0] cfg_data
);

	cmd_t   cmd;
	sts_t   sts;
	state_t state;

	rsat_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.op       (in_data.op),
		.sts      (sts),
		.in_stall (in_stall),
		.cmd      (cmd),
		.state    (state)
	);

	rsat_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	`ASSERT_NEXT(a_out_loaded, clk, arst_n, cmd.out_load, out_valid)
	`ASSERT_IMPL(a_div_idle, clk, arst_n, state == S_IDLE, sts.div_done)
	`ASSERT_IMPL(a_err_zero, clk, arst_n, out_valid && out_data.status != ST_OK, out_data.sum_red == '0 && out_data.variance == '0 && out_data.avg_blue == '0)

endmodule
